// File: hdl/daaq_pkg.sv
// Shared types and constants of the digital action auto-repeat qualifier.
package daaq_pkg;

  // Table size and widths.
  localparam int unsigned NUM_ACTIONS = 64;
  localparam int unsigned IDX_W       = $clog2(NUM_ACTIONS);
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned REQ_W       = 2;
  localparam int unsigned MODE_W      = 3;

  // Register values after reset.
  localparam logic [CFG_W-1:0] INITIAL_DELAY_RST = CFG_W'(250);
  localparam logic [CFG_W-1:0] REPEAT_PERIOD_RST = CFG_W'(150);
  localparam logic [CFG_W-1:0] FAST_PERIOD_RST   = CFG_W'(30);
  localparam logic [CFG_W-1:0] SPEEDUP_DELAY_RST = CFG_W'(1000);

  typedef enum logic [REQ_W-1:0] {
    REQ_POLL   = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_SET    = 2'd2
  } req_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE     = 3'd0,
    MODE_RELEASE  = 3'd1,
    MODE_CONT     = 3'd2,
    MODE_PRESS    = 3'd3,
    MODE_REPEAT   = 3'd4,
    MODE_TWO_RATE = 3'd5
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INITIAL_DELAY = 2'd0,
    CFG_REPEAT_PERIOD = 2'd1,
    CFG_FAST_PERIOD   = 2'd2,
    CFG_SPEEDUP_DELAY = 2'd3
  } cfg_idx_e;

  // One entry of the action table.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              pressed;
    logic              armed;
    logic [TIME_W-1:0] next_fire;
    logic [TIME_W-1:0] speedup;
  } entry_t;

endpackage

// File: hdl/digital_action_autorepeat_qualifier.sv
// Top level of the digital action auto-repeat qualifier.
//
// The block keeps a table of actions, each with a mode, a pressed flag, an
// armed flag, a next-fire time and a speed-up time, and turns each request
// into exactly one fire result. A poll request applies the action's mode
// (fire on release, continuous level, fire on press, auto-repeat, two-rate
// auto-repeat); a cancel request clears the action's press state and times;
// a set request stores a new mode. The block accepts one request in every
// cycle while it is not stalled. At the accepting edge the request is
// captured in the request register and its table entry is read into a
// registered read port; the mode logic between that register and the result
// register then loads the result into the result register as the request
// moves on, and it is offered there until taken. Requests are held back only
// while the result register is full and stalled. The table entry is written
// back as the request moves into the result register, and a request that
// follows at once on the same action takes the written entry from a bypass
// register, so back-to-back requests on one action are handled in order. The
// table is cleared at reset through a flag per entry; an entry whose flag is
// clear reads as all zero, so no clearing pass is needed and requests are
// taken from the first cycle after reset. Times are whole ticks compared with
// wrapping: a is later than b when a minus b, modulo the time width, is
// nonzero with its top bit clear. The user must write the timing registers
// through the configuration port only while the block is idle (not enforced).
module digital_action_autorepeat_qualifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [daaq_pkg::REQ_W-1:0]    req_type_i,
  input  logic [daaq_pkg::IDX_W-1:0]    action_index_i,
  input  logic                          level_i,
  input  logic                          gate_i,
  input  logic [daaq_pkg::TIME_W-1:0]   now_tick_i,
  input  logic [daaq_pkg::MODE_W-1:0]   new_mode_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          fire_o,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [daaq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [daaq_pkg::CFG_W-1:0]    cfg_data_i
);
  import daaq_pkg::*;

  // Timing registers.
  logic [CFG_W-1:0] initial_delay_q;
  logic [CFG_W-1:0] repeat_period_q;
  logic [CFG_W-1:0] fast_period_q;
  logic [CFG_W-1:0] speedup_delay_q;

  // Action table, its per-entry clear flags and the registered read.
  entry_t                 mem_q [NUM_ACTIONS];
  logic [NUM_ACTIONS-1:0] written_q;
  entry_t                 rd_q;
  logic                   rd_written_q;
  entry_t                 byp_q;
  logic                   byp_hit_q;

  // Request register.
  logic              s1_vld_q;
  logic [REQ_W-1:0]  s1_req_q;
  logic [IDX_W-1:0]  s1_idx_q;
  logic              s1_lvl_q;
  logic              s1_gate_q;
  logic [TIME_W-1:0] s1_now_q;
  logic [MODE_W-1:0] s1_mode_q;

  // Result register.
  logic out_vld_q;
  logic fire_q;

  logic   in_acc;
  logic   s1_adv;
  logic   wb_en;
  entry_t cur;
  entry_t nxt;
  logic   fire_d;
  logic   two_rate;
  logic   fast_now;
  logic   due_now;
  logic [CFG_W-1:0] period;

  // Wrapping time compare: a is later than b.
  function automatic logic is_later(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return (d != '0) && !d[TIME_W-1];
  endfunction

  // Handshake: the request register moves on whenever the result register
  // is empty or being emptied, so a new request can enter every cycle.
  // Every request writes its entry back; the unused request code leaves the
  // entry as it was read.
  assign s1_adv     = s1_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = s1_vld_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign wb_en      = s1_adv;

  // The entry as it stands now: the bypass covers a write-back that landed
  // in the same cycle as the read, and an entry never written reads as zero.
  always_comb begin
    if (byp_hit_q) begin
      cur = byp_q;
    end else if (rd_written_q) begin
      cur = rd_q;
    end else begin
      cur = '0;
    end
  end

  assign two_rate = (cur.mode == MODE_TWO_RATE);
  assign fast_now = two_rate && is_later(s1_now_q, cur.speedup);
  assign due_now  = is_later(s1_now_q, cur.next_fire);
  assign period   = fast_now ? fast_period_q : repeat_period_q;

  // Mode logic: next entry and fire result of the request in the register.
  always_comb begin
    nxt    = cur;
    fire_d = 1'b0;
    unique case (s1_req_q)
      REQ_CANCEL: begin
        nxt.pressed   = 1'b0;
        nxt.armed     = 1'b0;
        nxt.next_fire = '0;
        nxt.speedup   = '0;
      end
      REQ_SET: begin
        nxt.mode = s1_mode_q;
      end
      REQ_POLL: begin
        unique case (cur.mode)
          MODE_RELEASE: begin
            if (s1_gate_q) begin
              if (cur.pressed) begin
                if (!s1_lvl_q) begin
                  nxt.pressed = 1'b0;
                  fire_d      = 1'b1;
                end
              end else if (s1_lvl_q) begin
                nxt.pressed = 1'b1;
              end
            end
          end
          MODE_CONT: begin
            fire_d = s1_lvl_q && s1_gate_q;
          end
          MODE_PRESS: begin
            // The gate plays no part in press mode.
            if (cur.pressed) begin
              if (!s1_lvl_q) begin
                nxt.pressed = 1'b0;
              end
            end else if (s1_lvl_q) begin
              nxt.pressed = 1'b1;
              fire_d      = 1'b1;
            end
          end
          MODE_REPEAT, MODE_TWO_RATE: begin
            if (s1_gate_q) begin
              if (cur.pressed) begin
                if (s1_lvl_q) begin
                  // Held: fire once the next fire time has passed, if armed.
                  if (cur.armed && due_now) begin
                    nxt.next_fire = s1_now_q + TIME_W'(period);
                    fire_d        = 1'b1;
                  end
                end else begin
                  nxt.pressed   = 1'b0;
                  nxt.armed     = 1'b0;
                  nxt.next_fire = '0;
                  nxt.speedup   = '0;
                end
              end else if (s1_lvl_q) begin
                // First press fires at once and arms both deadlines.
                nxt.pressed   = 1'b1;
                nxt.armed     = 1'b1;
                nxt.next_fire = s1_now_q + TIME_W'(initial_delay_q);
                nxt.speedup   = s1_now_q + TIME_W'(speedup_delay_q);
                fire_d        = 1'b1;
              end
            end
          end
          default: begin
            // Mode none and the undefined mode codes do nothing.
          end
        endcase
      end
      default: begin
        // The unused request code is dropped with a zero result.
      end
    endcase
  end

  // Timing registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initial_delay_q <= INITIAL_DELAY_RST;
      repeat_period_q <= REPEAT_PERIOD_RST;
      fast_period_q   <= FAST_PERIOD_RST;
      speedup_delay_q <= SPEEDUP_DELAY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_INITIAL_DELAY: initial_delay_q <= cfg_data_i;
        CFG_REPEAT_PERIOD: repeat_period_q <= cfg_data_i;
        CFG_FAST_PERIOD:   fast_period_q   <= cfg_data_i;
        CFG_SPEEDUP_DELAY: speedup_delay_q <= cfg_data_i;
      endcase
    end
  end

  // Action table memory: one write-back port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wb_en) begin
      mem_q[s1_idx_q] <= nxt;
    end
    if (in_acc) begin
      rd_q <= mem_q[action_index_i];
    end
  end

  // Per-entry flags: cleared at reset, set by the first write-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
      byp_hit_q    <= 1'b0;
    end else begin
      if (wb_en) begin
        written_q[s1_idx_q] <= 1'b1;
      end
      if (in_acc) begin
        rd_written_q <= written_q[action_index_i];
        byp_hit_q    <= wb_en && (s1_idx_q == action_index_i);
      end
    end
  end

  // Request payload and bypass copy.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_req_q  <= req_type_i;
      s1_idx_q  <= action_index_i;
      s1_lvl_q  <= level_i;
      s1_gate_q <= gate_i;
      s1_now_q  <= now_tick_i;
      s1_mode_q <= new_mode_i;
      byp_q     <= nxt;
    end
    if (s1_adv) begin
      fire_q <= fire_d;
    end
  end

  // Valid flags of the request and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign fire_o      = fire_q;

endmodule

// File: hdl/daaq_checker.sv
// Port-level checker of the digital action auto-repeat qualifier, with its bind.
module daaq_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic [daaq_pkg::REQ_W-1:0]     req_type_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic                           fire_o
);
  import daaq_pkg::*;

  // A stalled result stays in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(fire_o))
    else $error("stalled result changed or vanished");

  // Requests are held back only while a finished result waits to be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("request stalled with the result side free");

  // A cancel, set or unused request passes the request and result registers
  // and reaches the output with a zero result if the output is free in between.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (req_type_i != REQ_POLL))
      ##1 (!out_valid_o || !out_stall_i)
      |=> out_valid_o && !fire_o)
    else $error("non-poll request did not give a zero result in time");

endmodule

bind digital_action_autorepeat_qualifier daaq_checker u_daaq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .req_type_i  (req_type_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .fire_o      (fire_o)
);
